>>> sv/rms_normalizer_macros.svh
// Assertion macros used by the back part of the block.
`ifndef RMS_NORMALIZER_MACROS_SVH
`define RMS_NORMALIZER_MACROS_SVH
// Checks that a condition implies a consequence in the same cycle.
`define RMSN_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);
// Checks that a condition implies a consequence in the next cycle.
`define RMSN_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);
`endif

>>> sv/rmsn_pkg.sv
`timescale 1ns / 1ps
package rmsn_pkg;
    localparam int MaxLength = 8192;
    localparam int SampleBits = 16;
    localparam int CountBits = 14;
    localparam int EpsBits = 24;
    localparam int SumBits = 48;
    localparam int InvBits = 32;
    localparam int CfgIdxBits = 1;

    localparam logic [CfgIdxBits-1:0] RegElementCount = 1'b0;
    localparam logic [CfgIdxBits-1:0] RegEpsilon = 1'b1;

    localparam logic OpAccumulate = 1'b0;
    localparam logic OpScale = 1'b1;
    localparam logic KindInvRms = 1'b0;
    localparam logic KindSample = 1'b1;

    // Job handed from the front part to the back part.
    typedef struct packed {
        logic                  finish;  // 1: compute inverse rms of sum
        logic [SumBits-1:0]    sum;
        logic [CountBits-1:0]  count;
        logic signed [SampleBits-1:0] sample;
    } t_job;

    localparam int JobBits = $bits(t_job);
    localparam int QueueDepth = 4;
    localparam int QueueAw = $clog2(QueueDepth);
endpackage

>>> sv/rmsn_ram.sv
`timescale 1ns / 1ps
module rmsn_ram #(
    parameter int Width = 8,
    parameter int Depth = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> sv/rmsn_front.sv
`timescale 1ns / 1ps
module rmsn_front import rmsn_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CfgIdxBits-1:0]        i_cfg_index,
    input  logic [EpsBits-1:0]           i_cfg_data,
    input  logic                         i_push,
    output logic                         o_full,
    input  logic                         i_operation,
    input  logic signed [SampleBits-1:0] i_sample,
    output logic                         o_job_valid,
    output t_job                         o_job,
    input  logic                         i_job_ready,
    output logic [EpsBits-1:0]           o_epsilon
);
    logic [CountBits-1:0] r_count_cfg;
    logic [EpsBits-1:0]   r_eps;
    logic [SumBits-1:0]   r_sum;
    logic [CountBits-1:0] r_taken;
    logic [CountBits-1:0] w_count;
    logic [SampleBits-1:0] w_mag;
    logic [2*SampleBits-1:0] w_sq;
    logic [SumBits:0]     w_sum_ext;
    logic [SumBits-1:0]   w_sum;
    logic [CountBits-1:0] w_taken;
    logic                 w_done;
    logic                 w_acc;

    assign o_full = !i_job_ready;
    assign w_acc = i_push && !o_full;
    assign o_epsilon = r_eps;

    always_comb begin
        w_count = r_count_cfg;
        if (w_count == '0) w_count = CountBits'(1);
        if (w_count > CountBits'(MaxLength)) w_count = CountBits'(MaxLength);
        w_mag = i_sample[SampleBits-1] ? SampleBits'(-i_sample) : SampleBits'(i_sample);
        w_sq = w_mag * w_mag;
        w_sum_ext = {1'b0, r_sum} + (SumBits+1)'(w_sq);
        w_sum = w_sum_ext[SumBits] ? {SumBits{1'b1}} : w_sum_ext[SumBits-1:0];
        w_taken = r_taken + CountBits'(1);
        w_done = (w_taken >= w_count);
    end

    always_comb begin
        o_job_valid = w_acc && ((i_operation == OpScale) || w_done);
        o_job.finish = (i_operation == OpAccumulate);
        o_job.sum = w_sum;
        o_job.count = w_count;
        o_job.sample = i_sample;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_cfg <= CountBits'(1);
            r_eps <= EpsBits'(1);
            r_sum <= '0;
            r_taken <= '0;
        end else begin
            if (i_cfg_we && i_cfg_index == RegElementCount) r_count_cfg <= i_cfg_data[CountBits-1:0];
            if (i_cfg_we && i_cfg_index == RegEpsilon) r_eps <= i_cfg_data;
            if (w_acc && i_operation == OpAccumulate) begin
                r_sum <= w_done ? '0 : w_sum;
                r_taken <= w_done ? '0 : w_taken;
            end
        end
    end
endmodule

>>> sv/rmsn_queue.sv
`timescale 1ns / 1ps
module rmsn_queue import rmsn_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wr,
    input  t_job   i_wdata,
    output logic   o_ready,
    output logic   o_valid,
    output t_job   o_rdata,
    input  logic   i_rd
);
    // Queue with registered RAM read and a one-entry output register.
    logic [QueueAw-1:0] r_wp, r_rp;
    logic [QueueAw:0]   r_cnt;
    logic               r_out_v, r_fetch;
    logic [JobBits-1:0] w_rdata;
    t_job               r_out;
    logic               w_fetch;

    assign o_ready = (r_cnt != (QueueAw+1)'(QueueDepth));
    assign o_valid = r_out_v;
    assign o_rdata = r_out;
    // Fetch one entry when the output register is free or will be freed and no fetch is in flight.
    assign w_fetch = (r_cnt != '0) && !r_fetch && (!r_out_v || i_rd);

    rmsn_ram #(.Width(JobBits), .Depth(QueueDepth)) u_ram (
        .i_clk(i_clk), .i_we(i_wr && o_ready), .i_waddr(r_wp), .i_wdata(i_wdata),
        .i_raddr(r_rp), .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0; r_out_v <= 1'b0; r_fetch <= 1'b0;
        end else begin
            if (i_wr && o_ready) r_wp <= r_wp + QueueAw'(1);
            if (w_fetch) r_rp <= r_rp + QueueAw'(1);
            r_cnt <= r_cnt + (QueueAw+1)'(i_wr && o_ready) - (QueueAw+1)'(w_fetch);
            r_fetch <= w_fetch;
            if (r_fetch) r_out_v <= 1'b1;
            else if (i_rd) r_out_v <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (r_fetch) r_out <= t_job'(w_rdata);
    end
endmodule

>>> sv/rmsn_back.sv
`timescale 1ns / 1ps
module rmsn_back import rmsn_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_job_valid,
    input  t_job                         i_job,
    output logic                         o_job_take,
    input  logic [EpsBits-1:0]           i_epsilon,
    output logic                         o_empty,
    input  logic                         i_pop,
    output logic                         o_result_kind,
    output logic [InvBits-1:0]           o_inv_rms_value,
    output logic signed [SampleBits-1:0] o_normalized_sample
);
    `include "rms_normalizer_macros.svh"
    localparam logic [2:0] StIdle = 3'd0, StDiv = 3'd1, StQ = 3'd2, StRoot = 3'd3,
                           StScale = 3'd4, StOut = 3'd5, StMean = 3'd6;
    localparam int NumBits = 57;
    logic [2:0]  r_st;
    logic [5:0]  r_step;
    logic [SumBits-1:0] r_quo;
    logic [SumBits-1:0] r_rem;
    logic [CountBits-1:0] r_div;
    logic [NumBits-1:0] r_num;
    logic [NumBits-1:0] r_m;
    logic [NumBits-1:0] r_q;
    logic [NumBits:0]   r_qrem;
    logic [InvBits-1:0] r_r;
    logic [InvBits-1:0] r_held;
    logic signed [SampleBits-1:0] r_smp;
    logic [SampleBits+InvBits-1:0] r_prod;
    logic        r_kind;
    logic [InvBits-1:0] r_out_inv;
    logic signed [SampleBits-1:0] r_out_smp;
    logic [SumBits:0] w_rem_sh;
    logic [NumBits:0] w_qrem_sh;
    logic [InvBits-1:0] w_c;
    logic [2*InvBits-1:0] w_cc;
    logic [SampleBits-1:0] w_mag;
    logic [SampleBits+InvBits-1:0] w_adj;
    logic [SampleBits+InvBits-1:0] w_sh;
    logic signed [SampleBits:0] w_res;

    assign o_job_take = (r_st == StIdle) && i_job_valid;
    assign o_empty = (r_st != StOut);
    assign o_result_kind = r_kind;
    assign o_inv_rms_value = r_out_inv;
    assign o_normalized_sample = r_out_smp;

    always_comb begin
        w_rem_sh = {r_rem, r_quo[SumBits-1]};
        w_qrem_sh = {r_qrem[NumBits-1:0], r_num[NumBits-1]};
        w_c = r_r | (InvBits'(1) << r_step[4:0]);
        w_cc = w_c * w_c;
        w_mag = r_smp[SampleBits-1] ? SampleBits'(-r_smp) : SampleBits'(r_smp);
        w_adj = r_prod + (SampleBits+InvBits)'(16'hFFFF);
        w_sh = r_smp[SampleBits-1] ? (w_adj >> 16) : (r_prod >> 16);
        if (r_smp[SampleBits-1])
            w_res = (w_sh > (SampleBits+InvBits)'(32768)) ? -(SampleBits+1)'(32768)
                    : -(SampleBits+1)'(w_sh);
        else
            w_res = (w_sh > (SampleBits+InvBits)'(32767)) ? (SampleBits+1)'(32767)
                    : (SampleBits+1)'(w_sh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= StIdle;
            r_held <= '0;
            r_step <= '0;
        end else begin
            unique case (r_st)
                StIdle: if (i_job_valid) begin
                    r_smp <= i_job.sample;
                    r_quo <= i_job.sum; r_rem <= '0; r_div <= i_job.count;
                    r_step <= 6'd47;
                    r_st <= i_job.finish ? StDiv : StScale;
                end
                StDiv: begin
                    // Restoring division of the sum by the count, one bit a cycle.
                    if (w_rem_sh >= (SumBits+1)'(r_div)) begin
                        r_rem <= SumBits'(w_rem_sh - (SumBits+1)'(r_div));
                        r_quo <= {r_quo[SumBits-2:0], 1'b1};
                    end else begin
                        r_rem <= SumBits'(w_rem_sh);
                        r_quo <= {r_quo[SumBits-2:0], 1'b0};
                    end
                    if (r_step == 6'd0) r_st <= StMean;
                    else r_step <= r_step - 6'd1;
                end
                StMean: begin
                    // Mean plus epsilon; a zero here saturates the inverse rms.
                    r_m <= NumBits'(r_quo) + NumBits'(i_epsilon);
                    r_num <= NumBits'(1) << 56; r_qrem <= '0; r_q <= '0;
                    r_step <= 6'd56;
                    r_st <= StQ;
                end
                StQ: begin
                    if (r_m == '0) begin
                        r_st <= StOut; r_kind <= KindInvRms;
                        r_held <= '1; r_out_inv <= '1; r_out_smp <= '0;
                    end else begin
                        // 2^56 / m, one quotient bit a cycle.
                        if (w_qrem_sh >= {1'b0, r_m}) begin
                            r_qrem <= w_qrem_sh - {1'b0, r_m};
                            r_q <= {r_q[NumBits-2:0], 1'b1};
                        end else begin
                            r_qrem <= w_qrem_sh;
                            r_q <= {r_q[NumBits-2:0], 1'b0};
                        end
                        r_num <= {r_num[NumBits-2:0], 1'b0};
                        if (r_step == 6'd0) begin
                            r_st <= StRoot; r_step <= 6'd28; r_r <= '0;
                        end else r_step <= r_step - 6'd1;
                    end
                end
                StRoot: begin
                    if (NumBits'(w_cc) <= r_q && w_cc[63:NumBits] == '0) r_r <= w_c;
                    if (r_step == 6'd0) r_st <= StScale;
                    else r_step <= r_step - 6'd1;
                    if (r_step == 6'd0) r_step <= 6'd63;
                end
                StScale: begin
                    if (r_step == 6'd63) begin
                        r_held <= r_r; r_out_inv <= r_r; r_kind <= KindInvRms;
                        r_out_smp <= '0; r_st <= StOut;
                    end else if (r_step == 6'd47) begin
                        r_prod <= w_mag * r_held; r_step <= 6'd46;
                    end else begin
                        r_out_smp <= w_res[SampleBits-1:0]; r_out_inv <= '0;
                        r_kind <= KindSample; r_st <= StOut;
                    end
                end
                StOut: if (i_pop) r_st <= StIdle;
                default: r_st <= StIdle;
            endcase
        end
    end

    `RMSN_ASSERT_IMPL(a_take_idle, i_clk, i_rst_n, o_job_take, r_st == StIdle, "take outside idle")
    `RMSN_ASSERT_NEXT(a_pop_idle, i_clk, i_rst_n, !o_empty && i_pop, o_empty, "pop did not free result")
    `RMSN_ASSERT_IMPL(a_kind_inv, i_clk, i_rst_n, !o_empty && o_result_kind == KindInvRms,
        o_normalized_sample == '0, "inverse rms result carries sample")
endmodule

>>> sv/rms_normalizer.sv
`timescale 1ns / 1ps
// RMS normalizer. Input channel: drive i_operation and i_sample with push;
// a transfer happens on a clock edge where push is high and full is low.
// Accumulate items add the sample square to a running sum; the item that
// completes element_count samples produces an inverse rms result (Q4.28).
// Scale items produce the sample times the held inverse rms (Q3.12).
// Result channel: a result is shown while empty is low and transfers on an
// edge where pop is high. Accumulate items that finish no block give no
// result and never leave the front part.
// A scale result passes the queue and the back part's product and
// rounding steps; an inverse rms result passes the bit-serial 48-bit mean
// divider, the 57-bit reciprocal divider and the 29-step root search, all
// in the back part, which handles one job at a time.
// A job queue of four entries plus an output register sits between front
// and back, so accumulation goes on at one sample per cycle while the back
// part works or the receiver stalls; when the queue fills, full rises.
// Reset (synchronous, active low) clears sum, count, held value and queue;
// element_count and epsilon return to one. Write registers only when idle.
module rms_normalizer import rmsn_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CfgIdxBits-1:0]        i_cfg_index,
    input  logic [EpsBits-1:0]           i_cfg_data,
    input  logic                         push,
    output logic                         full,
    input  logic                         i_operation,
    input  logic signed [SampleBits-1:0] i_sample,
    output logic                         empty,
    input  logic                         pop,
    output logic                         o_result_kind,
    output logic [InvBits-1:0]           o_inv_rms_value,
    output logic signed [SampleBits-1:0] o_normalized_sample
);
    logic               w_job_valid, w_q_ready, w_q_valid, w_take;
    t_job               w_job, w_q_job;
    logic [EpsBits-1:0] w_eps;

    rmsn_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data), .i_push(push), .o_full(full), .i_operation(i_operation),
        .i_sample(i_sample), .o_job_valid(w_job_valid), .o_job(w_job),
        .i_job_ready(w_q_ready), .o_epsilon(w_eps)
    );

    rmsn_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr(w_job_valid), .i_wdata(w_job),
        .o_ready(w_q_ready), .o_valid(w_q_valid), .o_rdata(w_q_job), .i_rd(w_take)
    );

    rmsn_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job_valid(w_q_valid), .i_job(w_q_job),
        .o_job_take(w_take), .i_epsilon(w_eps), .o_empty(empty), .i_pop(pop),
        .o_result_kind(o_result_kind), .o_inv_rms_value(o_inv_rms_value),
        .o_normalized_sample(o_normalized_sample)
    );
endmodule

>>> tb/rms_normalizer_tb.sv
`timescale 1ns / 1ps
module rms_normalizer_tb;
    import rmsn_pkg::*;

    // One expected or observed result of the normalizer.
    typedef struct packed {
        logic                  kind;
        logic [InvBits-1:0]    inv_rms;
        logic [SampleBits-1:0] norm;
    } t_norm_result;

    // Scoreboard: holds its own copy of the normalizer state and the queue of
    // results that accepted items are still owed.
    class norm_scoreboard;
        bit [CountBits-1:0] cfg_count;
        bit [EpsBits-1:0]   cfg_eps;
        bit [63:0]          sum_sq;
        bit [CountBits-1:0] taken;
        bit [31:0]          held_inv;
        t_norm_result       owed[$];
        int                 errors;
        int                 n_inv;
        int                 n_norm;

        function void reset_state();
            cfg_count = 1;
            cfg_eps = 1;
            sum_sq = 0;
            taken = 0;
            held_inv = 0;
        endfunction

        function void set_reg(logic [CfgIdxBits-1:0] idx, logic [EpsBits-1:0] val);
            if (idx == RegElementCount) cfg_count = val[CountBits-1:0];
            else cfg_eps = val;
        endfunction

        // Largest r with r*r <= 2^56 / m, found one bit at a time.
        function bit [31:0] inv_root(bit [63:0] m);
            bit [63:0] q;
            bit [63:0] r;
            bit [63:0] c;
            if (m == 0) return 32'hFFFF_FFFF;
            q = (64'd1 << 56) / m;
            r = 0;
            for (int b = 28; b >= 0; b--) begin
                c = r | (64'd1 << b);
                if (c * c <= q) r = c;
            end
            return r[31:0];
        endfunction

        function void note_input(logic op, logic signed [SampleBits-1:0] s);
            bit [63:0]        mag;
            bit [63:0]        cnt;
            bit [63:0]        prod;
            longint           res;
            t_norm_result     e;
            mag = (s < 0) ? 64'(-longint'(s)) : 64'(longint'(s));
            if (op == OpAccumulate) begin
                cnt = (cfg_count == 0) ? 1 : cfg_count;
                if (cnt > MaxLength) cnt = MaxLength;
                if (mag * mag > (64'd1 << 48) - 1 - sum_sq) sum_sq = (64'd1 << 48) - 1;
                else sum_sq += mag * mag;
                taken = taken + 1'b1;
                if (taken < cnt) return;
                held_inv = inv_root(sum_sq / cnt + cfg_eps);
                sum_sq = 0;
                taken = 0;
                e.kind = KindInvRms;
                e.inv_rms = held_inv;
                e.norm = 0;
            end else begin
                prod = mag * held_inv;
                // Negative products round toward minus infinity.
                if (s < 0) res = -longint'((prod + 64'hFFFF) >> 16);
                else res = longint'(prod >> 16);
                if (res > 32767) res = 32767;
                if (res < -32768) res = -32768;
                e.kind = KindSample;
                e.inv_rms = 0;
                e.norm = res[15:0];
            end
            owed.push_back(e);
        endfunction

        function void check_result(t_norm_result got);
            t_norm_result e;
            if (owed.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %h", $time, got);
                errors++;
                return;
            end
            e = owed.pop_front();
            if (got.kind == KindInvRms) n_inv++;
            else n_norm++;
            if (got.kind !== e.kind) begin
                $display("%0t: result_kind: expected %0d, actual %0d", $time, e.kind, got.kind);
                errors++;
            end
            if (got.inv_rms !== e.inv_rms) begin
                $display("%0t: inv_rms_value: expected %h, actual %h",
                         $time, e.inv_rms, got.inv_rms);
                errors++;
            end
            if (got.norm !== e.norm) begin
                $display("%0t: normalized_sample: expected %h, actual %h",
                         $time, e.norm, got.norm);
                errors++;
            end
        endfunction
    endclass

    localparam int WatchdogLimit = 20000;
    localparam int DrainCycles = 300;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_we = 1'b0;
    logic [CfgIdxBits-1:0]        i_cfg_index = '0;
    logic [EpsBits-1:0]           i_cfg_data = '0;
    logic                         push = 1'b0;
    logic                         full;
    logic                         i_operation = 1'b0;
    logic signed [SampleBits-1:0] i_sample = '0;
    logic                         empty;
    logic                         pop = 1'b0;
    logic                         o_result_kind;
    logic [InvBits-1:0]           o_inv_rms_value;
    logic signed [SampleBits-1:0] o_normalized_sample;

    norm_scoreboard sb = new();
    int push_idle_pct = 0;   // Chance in percent that the sender skips a cycle.
    int pop_idle_pct = 0;    // Chance in percent that the receiver stalls.
    int quiet_cycles = 0;
    int n_items = 0;

    always #2 i_clk = ~i_clk;

    rms_normalizer DUT (.*);

    // The receiver: pop is redrawn every edge, and a transfer is judged from
    // the values that were in place just before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            sb.check_result('{o_result_kind, o_inv_rms_value, o_normalized_sample});
        pop <= i_rst_n && ($urandom_range(99) >= pop_idle_pct);
    end

    // The watchdog counts cycles in which neither side completes a transfer.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit) begin
            $display("Watchdog expired with %0d results owed", sb.owed.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offers one item and holds it until the block takes it. Idle cycles are
    // inserted before the offer, so push drops only between items.
    task automatic send_item(logic op, logic signed [SampleBits-1:0] s);
        while ($urandom_range(99) < push_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_operation <= op;
        i_sample <= s;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_input(op, s);
        n_items++;
    endtask

    // Registers change only when the block is idle: all owed results are in and
    // the back part has had time to finish any division it started.
    task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [EpsBits-1:0] val);
        push <= 1'b0;
        @(posedge i_clk);
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    function automatic logic signed [SampleBits-1:0] rand_sample();
        case ($urandom_range(5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return SampleBits'($urandom_range(63)) - 16'sd32;
            default: return SampleBits'($urandom);
        endcase
    endfunction

    // A random phase: mostly whole blocks of accumulates, each followed by
    // up to four scale items, with stray scale items mixed in.
    task automatic random_phase(int items);
        int done;
        done = 0;
        while (done < items) begin
            if ($urandom_range(9) == 0) begin
                send_item(OpScale, rand_sample());
                done++;
            end else begin
                repeat (sb.cfg_count) send_item(OpAccumulate, rand_sample());
                repeat ($urandom_range(4)) send_item(OpScale, rand_sample());
                done += sb.cfg_count + 2;
            end
        end
    endtask

    initial begin
        sb.reset_state();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. A scale before any inverse rms must give zero.
        send_item(OpScale, 16'sh7FFF);
        send_item(OpScale, 16'sh8000);
        // With count one each accumulate emits; zero mean and zero epsilon
        // saturates the inverse rms.
        send_item(OpAccumulate, 16'sh7FFF);
        send_item(OpScale, 16'sh8000);
        send_item(OpScale, 16'sh7FFF);
        write_reg(RegEpsilon, 24'd0);
        send_item(OpAccumulate, 16'sh0000);
        send_item(OpScale, 16'sh7FFF);
        send_item(OpScale, 16'sh8000);
        send_item(OpScale, 16'shFFFF);
        send_item(OpScale, 16'sh0000);
        send_item(OpAccumulate, 16'sh8000);
        send_item(OpScale, 16'sh0001);
        send_item(OpScale, 16'shFFFF);
        // A zero element count acts as one.
        write_reg(RegElementCount, 14'd0);
        send_item(OpAccumulate, 16'sh1000);
        send_item(OpScale, 16'sh5555);
        // Lowering the count below the samples already taken makes the next
        // accumulate finish the block.
        write_reg(RegElementCount, 14'd8);
        repeat (5) send_item(OpAccumulate, 16'shAAAA);
        write_reg(RegEpsilon, 24'hFFFFFF);
        write_reg(RegElementCount, 14'd2);
        send_item(OpAccumulate, 16'sh0123);
        send_item(OpScale, 16'shC000);

        // Random phases under the three idling profiles and several settings.
        push_idle_pct = 25;
        pop_idle_pct = 61;
        write_reg(RegElementCount, 14'd3);
        write_reg(RegEpsilon, 24'd1);
        random_phase(550);
        push_idle_pct = 61;
        pop_idle_pct = 25;
        write_reg(RegElementCount, 14'd1);
        write_reg(RegEpsilon, 24'd0);
        random_phase(400);
        write_reg(RegElementCount, 14'd16);
        write_reg(RegEpsilon, 24'($urandom));
        random_phase(150);
        push_idle_pct = 0;
        pop_idle_pct = 0;
        write_reg(RegElementCount, 14'd5);
        write_reg(RegEpsilon, 24'hFFFFFF);
        random_phase(300);
        write_reg(RegElementCount, 14'd4);
        write_reg(RegEpsilon, 24'd0);
        random_phase(300);

        push <= 1'b0;
        @(posedge i_clk);
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        $display("Sent %0d items under three idling profiles and a range of register settings.",
                 n_items);
        $display("Checked %0d inverse rms results and %0d normalized samples.",
                 sb.n_inv, sb.n_norm);
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
